// ===== rtl/fat12cs_pkg.sv =====
`timescale 1ns / 1ps
package fat12cs_pkg;

   // Table size used when the top level is not told otherwise.
   localparam int TABLE_BYTES_DEFAULT = 8192;

   // Field widths.
   localparam int ADDR_W      = 13;
   localparam int BYTE_W      = 8;
   localparam int CLUSTER_W   = 12;
   localparam int SECTOR_W    = 32;
   localparam int BPS_W       = 16;
   localparam int SPC_W       = 8;
   localparam int RSV_W       = 16;
   localparam int SPF_W       = 16;
   localparam int FC_W        = 8;
   localparam int ROOT_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Request and response packing widths.
   localparam int REQ_FIELDS_W = ADDR_W + BYTE_W + CLUSTER_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SECTOR_W + SPC_W + CLUSTER_W + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // FAT byte offset of a 12-bit entry: cluster * 3 / 2 never exceeds 13 bits.
   localparam int OFF_W = 13;

   // Data region arithmetic.
   localparam int DIR_ENTRY_SHIFT = 5;
   localparam int DIVIDEND_W      = ROOT_W + DIR_ENTRY_SHIFT;
   localparam int FAT_PROD_W      = SPF_W + FC_W;
   localparam int STEP_MUL_W      = CLUSTER_W + SPC_W;

   // FAT12 entry codes.
   localparam logic [CLUSTER_W-1:0] ENTRY_MASK         = 12'hFFF;
   localparam logic [CLUSTER_W-1:0] CHAIN_END          = 12'hFF8;
   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BYTES_PER_SECTOR    = 3'd0,
      REG_SECTORS_PER_CLUSTER = 3'd1,
      REG_RESERVED_SECTORS    = 3'd2,
      REG_SECTORS_PER_FAT     = 3'd3,
      REG_FAT_COPIES          = 3'd4,
      REG_ROOT_ENTRIES        = 3'd5
   } reg_index_type;

   // Geometry after reset (a 1.44 MB floppy layout).
   localparam logic [BPS_W-1:0]  BPS_RESET  = 16'd512;
   localparam logic [SPC_W-1:0]  SPC_RESET  = 8'd1;
   localparam logic [RSV_W-1:0]  RSV_RESET  = 16'd1;
   localparam logic [SPF_W-1:0]  SPF_RESET  = 16'd9;
   localparam logic [FC_W-1:0]   FC_RESET   = 8'd2;
   localparam logic [ROOT_W-1:0] ROOT_RESET = 16'd224;

   localparam int DATA_START_RESET_INT =
      int'(RSV_RESET) + int'(SPF_RESET) * int'(FC_RESET) +
      ((int'(ROOT_RESET) * 32) + int'(BPS_RESET) - 1) / int'(BPS_RESET);
   localparam logic [SECTOR_W-1:0] DATA_START_RESET = SECTOR_W'(DATA_START_RESET_INT);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic csr_write;
      logic tbl_write;
      logic load_step;
      logic div_init;
      logic div_step;
      logic cfg_sum;
      logic reduce;
      logic rd_lo;
      logic rd_hi;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic off_ge_table;
   } dp_status_type;

endpackage

// ===== rtl/fat12_cluster_chain_step.sv =====
`timescale 1ns / 1ps
// FAT12 cluster chain step.
//
// The req channel carries two kinds of transfer, selected by req_tuser. A table
// write (tuser 0) stores one FAT byte and leaves the block idle; it gives no response.
// A step (tuser 1) names a cluster and gives one response on the rsp channel:
// the cluster's first sector, its sector count, the next cluster from the
// packed 12-bit entry, and the end-of-chain and reserved-cluster flags.
// A step is accepted in the idle state and keeps the block busy while it
// subtracts TABLE_BYTES from the entry's byte offset as often as it fits (never
// when the table covers all 4096 entries), reads the two FAT bytes one after the
// other through the single port of the table memory and loads its response
// into the output register, which raises rsp_tvalid.
// The csr channel writes the volume geometry. Each write starts a recompute of
// the data region start, a multiply, a restoring divide for the root directory
// sectors and a final sum, during which no transfer is taken.
// Reset restores the default geometry and its data start of 33 at once; the
// table contents stay undefined until written. A response waits in the output
// register while rsp_tready is low; the block keeps taking writes meanwhile,
// and a following step waits only in its final state for the register to free.
module fat12_cluster_chain_step #(
   parameter int TABLE_BYTES = fat12cs_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, from bit 0 up: table_address[12:0], table_byte[7:0],
   // cluster[11:0], zero fill.
   input  logic [fat12cs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: kind (0 table write, 1 step).
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata, from bit 0 up: first_sector[31:0], sector_count[7:0],
   // next_cluster[11:0], end_of_chain, bad_cluster, zero fill.
   output logic [fat12cs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fat12cs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fat12cs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fat12cs_pkg::*;

   dp_cmd_type              cmd;
   dp_status_type           status;
   logic [RSP_FIELDS_W-1:0] rsp_fields;

   fat12cs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fat12cs_dpath #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .table_address (req_tdata[ADDR_W-1:0]),
      .table_byte    (req_tdata[ADDR_W+BYTE_W-1:ADDR_W]),
      .cluster       (req_tdata[REQ_FIELDS_W-1:ADDR_W+BYTE_W]),
      .rsp_fields    (rsp_fields)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_fields);

`ifndef SYNTH
   // A geometry write holds off steps while the data start is recomputed.
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_tready)
      else $error("request taken right after a geometry write");

   // A step keeps the block busy for its table reads.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> (!req_tready && !csr_ready))
      else $error("transfer taken during a step");

   // A table write finishes in its own cycle and raises no response.
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser && !rsp_tvalid) |=>
      (!rsp_tvalid && csr_ready))
      else $error("table write produced a response or stalled");
`endif

endmodule

// ===== rtl/fat12cs_ctrl.sv =====
`timescale 1ns / 1ps
module fat12cs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_kind,
   output logic                       req_tready,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  fat12cs_pkg::dp_status_type status,
   output fat12cs_pkg::dp_cmd_type    cmd
);
   import fat12cs_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CFG_MUL,
      ST_CFG_DIV,
      ST_CFG_SUM,
      ST_REDUCE,
      ST_RD_LO,
      ST_RD_HI,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_xfer, csr_xfer, out_free;

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.csr_write = csr_xfer;
            cmd.tbl_write = req_xfer && !req_kind;
            cmd.load_step = req_xfer && req_kind;
            if (csr_xfer) begin
               state_in = ST_CFG_MUL;
            end else if (req_xfer && req_kind) begin
               state_in = ST_REDUCE;
            end
         end
         ST_CFG_MUL: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_CFG_DIV;
         end
         ST_CFG_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_CFG_SUM;
            end
         end
         ST_CFG_SUM: begin
            cmd.cfg_sum = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_REDUCE: begin
            if (status.off_ge_table) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/fat12cs_dpath.sv =====
`timescale 1ns / 1ps
module fat12cs_dpath #(
   parameter int TABLE_BYTES = fat12cs_pkg::TABLE_BYTES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fat12cs_pkg::dp_cmd_type                cmd,
   output fat12cs_pkg::dp_status_type             status,
   input  logic [fat12cs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fat12cs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [fat12cs_pkg::ADDR_W-1:0]         table_address,
   input  logic [fat12cs_pkg::BYTE_W-1:0]         table_byte,
   input  logic [fat12cs_pkg::CLUSTER_W-1:0]      cluster,
   output logic [fat12cs_pkg::RSP_FIELDS_W-1:0]   rsp_fields
);
   import fat12cs_pkg::*;

   localparam int AW = $clog2(TABLE_BYTES);

   // Geometry registers.
   logic [BPS_W-1:0]  bps_ff;
   logic [SPC_W-1:0]  spc_ff;
   logic [RSV_W-1:0]  rsv_ff;
   logic [SPF_W-1:0]  spf_ff;
   logic [FC_W-1:0]   fc_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SECTOR_W-1:0] data_start_ff;

   // Data region computation.
   logic [FAT_PROD_W-1:0] fat_prod_ff;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [BPS_W:0]        rem_ff, rem_in, rem_shift;
   logic [DIVIDEND_W:0]   dir_sectors;

   // Step operands.
   logic [CLUSTER_W-1:0]  clus_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [STEP_MUL_W-1:0] step_mul_ff;
   logic [CLUSTER_W-1:0]  clus_m2;
   logic [OFF_W:0]        off_inc;

   // Table storage.
   logic [BYTE_W-1:0] tbl_mem [TABLE_BYTES];
   logic [BYTE_W-1:0] rdata_ff, lo_ff;
   logic [AW-1:0]     mem_addr, hi_addr;
   logic              mem_we, mem_re;

   // Result.
   logic [RSP_FIELDS_W-1:0] rsp_ff;
   logic [2*BYTE_W-1:0]     word;
   logic [CLUSTER_W-1:0]    next_entry;
   logic                    bad;
   logic [SECTOR_W-1:0]     first_sector;

   assign status.off_ge_table = (32'(off_ff) >= TABLE_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff        <= BPS_RESET;
         spc_ff        <= SPC_RESET;
         rsv_ff        <= RSV_RESET;
         spf_ff        <= SPF_RESET;
         fc_ff         <= FC_RESET;
         root_ff       <= ROOT_RESET;
         data_start_ff <= DATA_START_RESET;
      end else begin
         if (cmd.csr_write) begin
            unique case (csr_index)
               REG_BYTES_PER_SECTOR:    bps_ff  <= BPS_W'(csr_data);
               REG_SECTORS_PER_CLUSTER: spc_ff  <= SPC_W'(csr_data);
               REG_RESERVED_SECTORS:    rsv_ff  <= RSV_W'(csr_data);
               REG_SECTORS_PER_FAT:     spf_ff  <= SPF_W'(csr_data);
               REG_FAT_COPIES:          fc_ff   <= FC_W'(csr_data);
               REG_ROOT_ENTRIES:        root_ff <= ROOT_W'(csr_data);
               default: begin
               end
            endcase
         end
         if (cmd.cfg_sum) begin
            data_start_ff <= SECTOR_W'(rsv_ff) + SECTOR_W'(fat_prod_ff) +
                             SECTOR_W'(dir_sectors);
         end
      end
   end

   // Restoring divider: one quotient bit per cycle, dividend shifted out of quo.
   assign rem_shift = {rem_ff[BPS_W-1:0], quo_ff[DIVIDEND_W-1]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.div_init) begin
         quo_in = {root_ff, DIR_ENTRY_SHIFT'(0)};
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, bps_ff}) begin
            rem_in = rem_shift - {1'b0, bps_ff};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   // Round up to whole sectors; a zero sector size leaves no root sectors.
   assign dir_sectors = (bps_ff == '0) ? '0 :
                        ({1'b0, quo_ff} + (DIVIDEND_W + 1)'(rem_ff != '0));

   assign clus_m2 = cluster - FIRST_DATA_CLUSTER;

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.div_init) begin
         fat_prod_ff <= FAT_PROD_W'(spf_ff) * FAT_PROD_W'(fc_ff);
      end
      if (cmd.load_step) begin
         clus_ff     <= cluster;
         off_ff      <= OFF_W'(cluster) + OFF_W'(cluster >> 1);
         step_mul_ff <= STEP_MUL_W'(clus_m2) * STEP_MUL_W'(spc_ff);
      end else if (cmd.reduce) begin
         off_ff <= off_ff - OFF_W'(TABLE_BYTES);
      end
   end

   // The second byte of the pair wraps to the start of the table.
   assign off_inc = {1'b0, off_ff} + 1'b1;
   assign hi_addr = (32'(off_inc) == TABLE_BYTES) ? '0 : AW'(off_inc);

   assign mem_we = cmd.tbl_write && (32'(table_address) < TABLE_BYTES);
   assign mem_re = cmd.rd_lo || cmd.rd_hi;

   always_comb begin
      mem_addr = AW'(table_address);
      if (cmd.rd_lo) begin
         mem_addr = AW'(off_ff);
      end else if (cmd.rd_hi) begin
         mem_addr = hi_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_addr] <= table_byte;
      end else if (mem_re) begin
         rdata_ff <= tbl_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_hi) begin
         lo_ff <= rdata_ff;
      end
   end

   assign word       = {rdata_ff, lo_ff};
   assign next_entry = clus_ff[0] ? (word[2*BYTE_W-1:4] & ENTRY_MASK)
                                  : (word[CLUSTER_W-1:0] & ENTRY_MASK);
   assign bad        = (clus_ff < FIRST_DATA_CLUSTER);
   assign first_sector = bad ? '0 : (data_start_ff + SECTOR_W'(step_mul_ff));

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= {bad, (next_entry >= CHAIN_END), next_entry, spc_ff, first_sector};
      end
   end

   assign rsp_fields = rsp_ff;

endmodule
